/* hw/rtl/srs_pkg.sv */
// ============================================================================
// srs_pkg : shared types and constants of the stereo linear resampler
// Widths of the position, step and counter words, sequencer states,
// register offsets and the saturating position advance.
// ============================================================================
`default_nettype none

package srs_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_RUN_DEF     = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // Fixed-point layout: position is Q32.24, step is Q8.24
   localparam int FRAC_BITS = 24;
   localparam int POS_W     = 56;
   localparam int IDX_W     = 32;
   localparam int STEP_W    = 32;
   localparam int CNT_W     = 32;
   localparam int ADD_W     = 64;

   // Shared multiplier: 33 x 33 signed, covers 32 x 32 unsigned
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Divider quotient counter
   localparam int DIV_CNT_W = $clog2(POS_W);

   // Register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_PHASE_STEP  = 2'd0;
   localparam reg_idx_type REG_FRAME_TOTAL = 2'd1;
   localparam reg_idx_type REG_MONO        = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL_R,
      ST_EMIT,
      ST_DIV,
      ST_CLAMP,
      ST_ADV
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Position advance that saturates at the top of the position range
   function automatic logic [POS_W-1:0] sat_advance(input logic [POS_W-1:0] p,
                                                     input logic [ADD_W-1:0] d);
      logic [POS_W-1:0] room;
      room = POS_MAX - p;
      if (d > ADD_W'(room)) begin
         return POS_MAX;
      end
      return p + d[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/srs_mul.sv */
// ============================================================================
// srs_mul : shared signed multiplier with registered product
// One 33 x 33 product per enabled cycle; the product holds while idle.
// ============================================================================
`default_nettype none

module srs_mul (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic signed [srs_pkg::MUL_W-1:0]  op_a,
   input  wire logic signed [srs_pkg::MUL_W-1:0]  op_b,
   output logic signed      [srs_pkg::PROD_W-1:0] prod_ff
);

   logic signed [srs_pkg::PROD_W-1:0] prod_in;

   // product of the presented operands, captured only when enabled
   always_comb begin
      prod_in = prod_ff;
      if (en) begin
         prod_in = op_a * op_b;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/srs_div.sv */
// ============================================================================
// srs_div : restoring divider, one quotient bit per cycle
// Divides a 56-bit position distance by the 32-bit step; quotient and
// remainder are valid in the cycle done is high.
// ============================================================================
`default_nettype none

module srs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [srs_pkg::POS_W-1:0]     dividend,
   input  wire logic [srs_pkg::STEP_W-1:0]    divisor,
   output srs_pkg::div_stat_type              stat,
   output logic      [srs_pkg::POS_W-1:0]     quot_ff,
   output logic      [srs_pkg::STEP_W-1:0]    rem_ff
);

   logic [srs_pkg::POS_W-1:0]     quot_in;
   logic [srs_pkg::STEP_W-1:0]    rem_in;
   logic [srs_pkg::STEP_W-1:0]    dsor_ff, dsor_in;
   logic [srs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [srs_pkg::STEP_W:0]      trial;
   logic                          fits;

   // shift in next dividend bit, subtract when the divisor fits
   always_comb begin
      trial   = {rem_ff, quot_ff[srs_pkg::POS_W-1]};
      fits    = trial >= {1'b0, dsor_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsor_in = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[srs_pkg::POS_W-2:0], fits};
         rem_in  = fits ? srs_pkg::STEP_W'(trial - {1'b0, dsor_ff})
                        : trial[srs_pkg::STEP_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == srs_pkg::DIV_CNT_W'(srs_pkg::POS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/stereo_linear_resampler.sv */
// ============================================================================
// stereo_linear_resampler : linear-interpolation sample-rate converter
// Per input frame, emits the output frames whose positions fall before it,
// interpolated between the previous and current samples, through one shared
// multiplier and an iterative divider under a small sequencer.
// ============================================================================
//
//  channel  dir  handshake            payload
//  req_     in   tvalid/tready        tdata {right, left}, tlast = final input
//  rsp_     out  tvalid/tready        tdata {right, left}, tlast = run last,
//                                     tuser = stream end
//  csr_     in   psel/penable/pready  phase_step @0, frame total @4, mono @8
//
//  Steps: each input is accepted and then closed; each interpolated frame
//  takes a left multiply, a right multiply and an emit; each repeated final
//  frame is one emit. An interpolated run that passes MAX_RUN frames counts
//  the dropped frames on the bit-serial divider; a final run jumps to the total.
//  req_tready is high only while the sequencer is idle.
//  A held result beat stalls the sequencer at its next emit.
//  Reset clears sequencer state, position and counters and loads register defaults.
//
`default_nettype none

module stereo_linear_resampler #(
   parameter int MAX_RUN     = srs_pkg::MAX_RUN_DEF,
   parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input beats
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                              req_tdata,  // in_left, in_right
   input  wire logic                          req_tlast,
   // result beats
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                              rsp_tdata,  // out_left, out_right
   output logic                               rsp_tlast,
   output logic                               rsp_tuser,  // stream_end
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [srs_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [srs_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [srs_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RUN_W = $clog2(MAX_RUN + 1);
   localparam int ACC_W = SAMPLE_BITS + srs_pkg::FRAC_BITS + 2;
   localparam int SB    = SAMPLE_BITS;
   localparam int FB    = srs_pkg::FRAC_BITS;
   localparam int PW    = srs_pkg::POS_W;

   // rounding lerp: a + frac*(b-a), half up, back to sample scale
   function automatic logic [SB-1:0] lerp_fn(input logic signed [SB-1:0] a,
                                             input logic signed [srs_pkg::PROD_W-1:0] p);
      logic signed [ACC_W-1:0] a_ext;
      logic signed [ACC_W-1:0] p_ext;
      logic signed [ACC_W-1:0] acc;
      a_ext = ACC_W'(a);
      p_ext = ACC_W'(p);
      acc   = (a_ext <<< FB) + p_ext + (ACC_W'(1) << (FB - 1));
      return acc[FB+SB-1:FB];
   endfunction

   // registers
   logic [srs_pkg::STEP_W-1:0] step_ff, step_in;
   logic [srs_pkg::CNT_W-1:0]  total_ff, total_in;
   logic                       mono_ff, mono_in;
   logic                       csr_wr;

   // stream state
   srs_pkg::seq_state_type     state_ff, state_in;
   logic signed [SB-1:0]       cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic signed [SB-1:0]       prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic                       fin_ff, fin_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [srs_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [srs_pkg::CNT_W-1:0]  fo_ff, fo_in;
   logic [RUN_W-1:0]           run_ff, run_in;
   logic [FB-1:0]              frac_ff, frac_in;
   logic [SB-1:0]              res_l_ff, res_l_in;
   logic [srs_pkg::CNT_W-1:0]  drop_ff, drop_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]              rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;
   logic                       rsp_last_ff, rsp_last_in, rsp_end_ff, rsp_end_in;

   // shared units
   logic                               mul_en;
   logic signed [srs_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [srs_pkg::PROD_W-1:0]  mul_prod;
   logic                               div_start;
   srs_pkg::div_stat_type              div_stat;
   logic [PW-1:0]                      div_quot;
   logic [srs_pkg::STEP_W-1:0]         div_rem;

   // sequencer helpers
   logic [srs_pkg::STEP_W-1:0] eff_step;
   logic [PW-1:0]              lim, base, pos_diff;
   logic [FB-1:0]              frac_c;
   logic                       ph1, run_full, fo_open, slot_free;
   logic signed [SB:0]         diff_l, diff_r;
   logic [PW:0]                ceil_cnt;
   logic [srs_pkg::CNT_W-1:0]  fo_left, drop_c;
   logic                       emit_go;
   logic [SB-1:0]              emit_l, emit_r;
   logic                       emit_last, emit_end;

   // ---------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      step_in  = step_ff;
      total_in = total_ff;
      mono_in  = mono_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            srs_pkg::REG_PHASE_STEP:  step_in  = csr_pwdata;
            srs_pkg::REG_FRAME_TOTAL: total_in = csr_pwdata;
            srs_pkg::REG_MONO:        mono_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         srs_pkg::REG_PHASE_STEP:  csr_prdata = step_ff;
         srs_pkg::REG_FRAME_TOTAL: csr_prdata = total_ff;
         srs_pkg::REG_MONO:        csr_prdata = srs_pkg::CSR_DW'(mono_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // shared units
   // ---------------------------------------------------------------------
   srs_mul u_mul (
      .clock   (clock),
      .en      (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   srs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lim - pos_ff),
      .divisor  (eff_step),
      .stat     (div_stat),
      .quot_ff  (div_quot),
      .rem_ff   (div_rem)
   );

   // ---------------------------------------------------------------------
   // position window and shared decode
   // ---------------------------------------------------------------------
   always_comb begin
      eff_step  = (step_ff == '0) ? srs_pkg::STEP_W'(1) : step_ff;
      lim       = {idx_ff, {FB{1'b0}}};
      base      = {idx_ff - 1'b1, {FB{1'b0}}};
      pos_diff  = pos_ff - base;
      if (pos_ff < base) begin
         frac_c = '0;
      end else if (pos_diff[PW-1:FB] != '0) begin
         frac_c = '1;
      end else begin
         frac_c = pos_diff[FB-1:0];
      end
      fo_open   = fo_ff < total_ff;
      ph1       = (idx_ff != '0) && (pos_ff < lim) && fo_open;
      run_full  = run_ff == RUN_W'(MAX_RUN);
      slot_free = !rsp_valid_ff || rsp_tready;
      diff_l    = {cur_l_ff[SB-1], cur_l_ff} - {prev_l_ff[SB-1], prev_l_ff};
      diff_r    = {cur_r_ff[SB-1], cur_r_ff} - {prev_r_ff[SB-1], prev_r_ff};
      ceil_cnt  = {1'b0, div_quot} + (PW+1)'(div_rem != '0);
      fo_left   = total_ff - fo_ff;
      drop_c    = (ceil_cnt > (PW+1)'(fo_left)) ? fo_left
                                                : ceil_cnt[srs_pkg::CNT_W-1:0];
   end

   // ---------------------------------------------------------------------
   // sequencer: next state and datapath controls
   // ---------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      cur_l_in  = cur_l_ff;
      cur_r_in  = cur_r_ff;
      fin_in    = fin_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      fo_in     = fo_ff;
      run_in    = run_ff;
      frac_in   = frac_ff;
      res_l_in  = res_l_ff;
      drop_in   = drop_ff;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      emit_go   = 1'b0;
      emit_l    = cur_l_ff;
      emit_r    = cur_r_ff;
      emit_last = 1'b0;
      emit_end  = 1'b0;
      req_tready = state_ff == srs_pkg::ST_IDLE;

      unique case (state_ff)
         srs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cur_l_in = req_tdata[SB-1:0];
               cur_r_in = mono_ff ? req_tdata[SB-1:0] : req_tdata[2*SB-1:SB];
               fin_in   = req_tlast;
               run_in   = '0;
               state_in = srs_pkg::ST_SCAN;
            end
         end

         srs_pkg::ST_SCAN: begin
            priority if (ph1 && !run_full) begin
               // interpolated frame: start left product
               frac_in  = frac_c;
               mul_en   = 1'b1;
               mul_a    = srs_pkg::MUL_W'(frac_c);
               mul_b    = srs_pkg::MUL_W'(diff_l);
               state_in = srs_pkg::ST_MUL_R;
            end else if (ph1) begin
               // run is full: count the dropped frames
               div_start = 1'b1;
               state_in  = srs_pkg::ST_DIV;
            end else if (fin_ff && fo_open && !run_full) begin
               // final input: repeat its sample up to the total
               if (slot_free) begin
                  emit_go   = 1'b1;
                  emit_end  = (fo_ff + 1'b1) == total_ff;
                  emit_last = !((run_ff < RUN_W'(MAX_RUN - 1)) &&
                                ((fo_ff + 1'b1) < total_ff));
                  fo_in     = fo_ff + 1'b1;
                  run_in    = run_ff + 1'b1;
               end
            end else if (fin_ff && fo_open) begin
               fo_in = total_ff;
            end else begin
               // input done: roll state forward or close the stream
               if (fin_ff) begin
                  prev_l_in = '0;
                  prev_r_in = '0;
                  pos_in    = '0;
                  idx_in    = '0;
                  fo_in     = '0;
               end else begin
                  prev_l_in = cur_l_ff;
                  prev_r_in = cur_r_ff;
                  if (idx_ff != '1) begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               state_in = srs_pkg::ST_IDLE;
            end
         end

         srs_pkg::ST_MUL_R: begin
            mul_en   = 1'b1;
            mul_a    = srs_pkg::MUL_W'(frac_ff);
            mul_b    = srs_pkg::MUL_W'(diff_r);
            res_l_in = lerp_fn(prev_l_ff, mul_prod);
            pos_in   = srs_pkg::sat_advance(pos_ff, srs_pkg::ADD_W'(eff_step));
            fo_in    = fo_ff + 1'b1;
            state_in = srs_pkg::ST_EMIT;
         end

         srs_pkg::ST_EMIT: begin
            emit_l    = res_l_ff;
            emit_r    = lerp_fn(prev_r_ff, mul_prod);
            emit_end  = fo_ff == total_ff;
            emit_last = !((run_ff < RUN_W'(MAX_RUN - 1)) && fo_open &&
                          (fin_ff || (pos_ff < lim)));
            if (slot_free) begin
               emit_go  = 1'b1;
               run_in   = run_ff + 1'b1;
               state_in = srs_pkg::ST_SCAN;
            end
         end

         srs_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = srs_pkg::ST_CLAMP;
            end
         end

         srs_pkg::ST_CLAMP: begin
            // dropped count times step, on the shared multiplier
            drop_in  = drop_c;
            mul_en   = 1'b1;
            mul_a    = srs_pkg::MUL_W'(drop_c);
            mul_b    = srs_pkg::MUL_W'(eff_step);
            state_in = srs_pkg::ST_ADV;
         end

         srs_pkg::ST_ADV: begin
            pos_in   = srs_pkg::sat_advance(pos_ff, mul_prod[srs_pkg::ADD_W-1:0]);
            fo_in    = fo_ff + drop_ff;
            state_in = srs_pkg::ST_SCAN;
         end

         default: state_in = srs_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_l_in     = emit_l;
         rsp_r_in     = emit_r;
         rsp_last_in  = emit_last;
         rsp_end_in   = emit_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = IN_W'({rsp_r_ff, rsp_l_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_end_ff;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= srs_pkg::STEP_W'(1) << FB;
         total_ff     <= '0;
         mono_ff      <= 1'b0;
         state_ff     <= srs_pkg::ST_IDLE;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         fo_ff        <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         total_ff     <= total_in;
         mono_ff      <= mono_in;
         state_ff     <= state_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         fo_ff        <= fo_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_l_ff    <= cur_l_in;
      cur_r_ff    <= cur_r_in;
      fin_ff      <= fin_in;
      frac_ff     <= frac_in;
      res_l_ff    <= res_l_in;
      drop_ff     <= drop_in;
      rsp_l_ff    <= rsp_l_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the frame that reaches the total always closes its run
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> rsp_last_ff)
      else $error("stream end beat without run last");

   // the divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == srs_pkg::ST_DIV)
      else $error("divider busy outside its wait state");

   // a stream with no inputs taken yet sits at position zero
   a_pos_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == srs_pkg::ST_IDLE && idx_ff == '0 |-> pos_ff == '0)
      else $error("position nonzero at stream start");

   // the run counter never passes the run limit
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_W'(MAX_RUN))
      else $error("run counter past limit");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench : self-checking bench for the stereo linear resampler
// Drives int16 frames into the req_ stream and the three registers over the
// csr_ port, predicts every interpolated frame in a scoreboard class and
// checks each rsp_ beat field by field. It starts with directed streams:
// sample extremes, mono, zero and maximum step, run overflow, a frame total
// reached early, a zero total and a stream of one final frame. Random
// streams follow, with random gaps on both sides and one long output stall.
// ============================================================================

module testbench;

   localparam int RUN_CAP        = 64;
   localparam int SETTLE_CYCLES  = 100;    // idle pause before register writes
   localparam int HOLD_AT        = 40;     // result beat that starts the long stall
   localparam int HOLD_CYCLES    = 400;
   localparam int QUIET_LIMIT    = 4000;   // cycles without any beat
   localparam int RANDOM_ITEMS   = 80;
   localparam int MAX_REPORTS    = 10;

   localparam longint unsigned POS_TOP  = 64'h00FF_FFFF_FFFF_FFFF;
   localparam longint unsigned FRAC_TOP = 64'h0000_0000_00FF_FFFF;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic        run_last;
      logic        stream_end;
   } resampled_frame_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors registers and stream state, queues expected frames
   // -------------------------------------------------------------------------
   class frame_tracker_type;
      bit [31:0]           step_reg  = 32'h0100_0000;
      bit [31:0]           total_reg = 32'd0;
      bit                  mono_reg  = 1'b0;
      longint              prev_l;
      longint              prev_r;
      longint unsigned     pos;
      bit [31:0]           in_idx;
      bit [31:0]           frames;
      resampled_frame_type expected_frames[$];
      int                  errors;
      int                  inputs;
      int                  results;
      int                  streams;
      int                  settings;

      function void set_reg(srs_pkg::reg_idx_type idx, bit [31:0] value);
         case (idx)
            srs_pkg::REG_PHASE_STEP:  step_reg  = value;
            srs_pkg::REG_FRAME_TOTAL: total_reg = value;
            srs_pkg::REG_MONO:        mono_reg  = value[0];
            default: ;
         endcase
      endfunction

      function bit [31:0] reg_value(srs_pkg::reg_idx_type idx);
         case (idx)
            srs_pkg::REG_PHASE_STEP:  return step_reg;
            srs_pkg::REG_FRAME_TOTAL: return total_reg;
            srs_pkg::REG_MONO:        return {31'd0, mono_reg};
            default:                  return 32'd0;
         endcase
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
      endfunction

      function int pending();
         return expected_frames.size();
      endfunction

      // Linear interpolation with round half up on int16 scale
      function longint interp_sample(longint a, longint b, longint unsigned frac);
         longint acc;
         acc = a * 16777216 + longint'(frac) * (b - a) + 8388608 + 64'sh80_0000_0000;
         if (acc < 0) acc = 0;
         return (acc >> 24) - 32768;
      endfunction

      function longint unsigned sat_add(longint unsigned p, longint unsigned d);
         if (d > POS_TOP - p) return POS_TOP;
         return p + d;
      endfunction

      function void push_frame(longint lv, longint rv);
         resampled_frame_type f;
         frames++;
         f.left       = lv[15:0];
         f.right      = rv[15:0];
         f.run_last   = 1'b0;
         f.stream_end = (frames == total_reg);
         expected_frames.push_back(f);
      endfunction

      // One accepted input beat: work out every frame it releases
      function void note_input(logic signed [15:0] l, logic signed [15:0] r, logic fin);
         longint unsigned stp, lim, base, frac, cnt, remain;
         longint          cl, cr;
         int              n;
         stp = (step_reg == 0) ? 64'd1 : 64'(step_reg);
         cl  = l;
         cr  = mono_reg ? cl : longint'(r);
         n   = 0;
         inputs++;
         if (in_idx > 0) begin
            lim  = 64'(in_idx) << 24;
            base = 64'(in_idx - 32'd1) << 24;
            while (pos < lim && frames < total_reg) begin
               // run overflow: count the dropped frames in one go
               if (n >= RUN_CAP) begin
                  cnt    = (lim - pos + stp - 1) / stp;
                  remain = 64'(total_reg - frames);
                  if (cnt > remain) cnt = remain;
                  frames += cnt[31:0];
                  pos     = sat_add(pos, cnt * stp);
                  break;
               end
               frac = (pos >= base) ? pos - base : 64'd0;
               if (frac > FRAC_TOP) frac = FRAC_TOP;
               push_frame(interp_sample(prev_l, cl, frac), interp_sample(prev_r, cr, frac));
               n++;
               pos = sat_add(pos, stp);
            end
         end
         // final input: repeat its sample up to the frame total
         if (fin) begin
            while (frames < total_reg) begin
               if (n >= RUN_CAP) begin
                  frames = total_reg;
                  break;
               end
               push_frame(cl, cr);
               n++;
            end
         end
         if (n > 0) expected_frames[expected_frames.size()-1].run_last = 1'b1;
         if (fin) begin
            streams++;
            prev_l = 0;
            prev_r = 0;
            pos    = 0;
            in_idx = 0;
            frames = 0;
         end else begin
            prev_l = cl;
            prev_r = cr;
            if (in_idx != 32'hFFFF_FFFF) in_idx++;
         end
      endfunction

      function void check_result(logic [31:0] data, logic last, logic user);
         resampled_frame_type f;
         results++;
         if (expected_frames.size() == 0) begin
            flag($sformatf("beat %0d: unexpected L=%0d R=%0d last=%0b end=%0b",
                           results, $signed(data[15:0]), $signed(data[31:16]), last, user));
            return;
         end
         f = expected_frames.pop_front();
         if (f.left !== data[15:0] || f.right !== data[31:16] ||
             f.run_last !== last || f.stream_end !== user) begin
            flag($sformatf({"beat %0d: expected L=%0d R=%0d last=%0b end=%0b, ",
                            "got L=%0d R=%0d last=%0b end=%0b"},
                           results, $signed(f.left), $signed(f.right), f.run_last,
                           f.stream_end, $signed(data[15:0]), $signed(data[31:16]),
                           last, user));
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [31:0]                  req_tdata   = '0;  // in_left, in_right
   logic                         req_tlast   = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [31:0]                  rsp_tdata;         // out_left, out_right
   logic                         rsp_tlast;
   logic                         rsp_tuser;         // stream_end
   logic                         csr_psel    = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite  = 1'b0;
   logic [srs_pkg::CSR_AW-1:0]   csr_paddr   = '0;
   logic [srs_pkg::CSR_DW-1:0]   csr_pwdata  = '0;
   logic [srs_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   frame_tracker_type tracker = new();
   bit           tx_busy   = 1'b1;
   bit           rx_busy   = 1'b1;
   bit           hold_done = 1'b0;
   int           quiet_cycles = 0;

   stereo_linear_resampler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: ends the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles, %0d frames outstanding",
                  QUIET_LIMIT, tracker.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Register port
   // -------------------------------------------------------------------------
   task automatic csr_access(srs_pkg::reg_idx_type idx, bit wr, bit [31:0] value,
                             output bit [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= srs_pkg::CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata        = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_readback(srs_pkg::reg_idx_type idx);
      bit [31:0] rdata;
      csr_access(idx, 1'b0, 32'd0, rdata);
      if (rdata !== tracker.reg_value(idx))
         tracker.flag($sformatf("register %0d read %08h, expected %08h",
                                idx, rdata, tracker.reg_value(idx)));
   endtask

   task automatic csr_write(srs_pkg::reg_idx_type idx, bit [31:0] value);
      bit [31:0] unused;
      csr_access(idx, 1'b1, value, unused);
      tracker.set_reg(idx, value);
      csr_readback(idx);
   endtask

   // Sender pauses until all frames are out and the block has gone quiet
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(bit [31:0] step, bit [31:0] total, bit mono);
      settle_idle();
      csr_write(srs_pkg::REG_PHASE_STEP, step);
      csr_write(srs_pkg::REG_FRAME_TOTAL, total);
      csr_write(srs_pkg::REG_MONO, {31'd0, mono});
      tracker.settings++;
   endtask

   // -------------------------------------------------------------------------
   // Input beats
   // -------------------------------------------------------------------------
   task automatic send_frame(logic [15:0] l, logic [15:0] r, logic fin);
      int gap;
      if ($urandom_range(0, 15) == 0) tx_busy = !tx_busy;
      gap = tx_busy ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r, l};
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      tracker.note_input(l, r, fin);
   endtask

   function automatic logic [15:0] draw_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic bit [31:0] draw_step();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom;
         3:       return $urandom_range(1, 32'h0010_0000);
         default: return $urandom_range(32'h0040_0000, 32'h0280_0000);
      endcase
   endfunction

   function automatic bit [31:0] draw_total();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 120);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Result beats: random back-pressure plus one long stall
   // -------------------------------------------------------------------------
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && tracker.results >= HOLD_AT) begin
            hold_done = 1'b1;
            gap = HOLD_CYCLES;
         end else begin
            if ($urandom_range(0, 31) == 0) rx_busy = !rx_busy;
            gap = rx_busy ? $urandom_range(0, 14) : 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int target;
      int len;
      bit broken;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults after reset
      csr_readback(srs_pkg::REG_PHASE_STEP);
      csr_readback(srs_pkg::REG_FRAME_TOTAL);
      csr_readback(srs_pkg::REG_MONO);

      // unit step, sample extremes, final frame pads up to the total
      apply_config(32'h0100_0000, 32'd8, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'h7FFF, 16'h8000, 1'b0);
      send_frame(16'h0000, 16'h0000, 1'b0);
      send_frame(16'hFFFF, 16'h0001, 1'b0);
      send_frame(16'd12345, 16'hCFC7, 1'b1);

      // zero step in mono: run overflow on every input after the first, huge total
      apply_config(32'd0, 32'hFFFF_FFFF, 1'b1);
      send_frame(16'd100, 16'($urandom), 1'b0);
      send_frame(16'hFF38, 16'($urandom), 1'b0);
      send_frame(16'd300, 16'($urandom), 1'b1);

      // maximum step: one frame, then the final frame finishes the total
      apply_config(32'hFFFF_FFFF, 32'd3, 1'b0);
      send_frame(16'h7FFF, 16'h8000, 1'b0);
      send_frame(16'h8000, 16'h7FFF, 1'b0);
      send_frame(16'h1234, 16'h4321, 1'b0);
      send_frame(16'hAAAA, 16'h5555, 1'b0);
      send_frame(16'h5555, 16'hAAAA, 1'b1);

      // half step: total reached inside the first run
      apply_config(32'h0080_0000, 32'd2, 1'b1);
      send_frame(16'h8000, 16'h0F0F, 1'b0);
      send_frame(16'h7FFF, 16'hF0F0, 1'b0);
      send_frame(16'h0001, 16'h0002, 1'b0);
      send_frame(16'h0003, 16'h0004, 1'b1);

      // a stream of a single final frame
      apply_config(32'h0100_0000, 32'd5, 1'b0);
      send_frame(16'h8001, 16'h7FFE, 1'b1);

      // zero total issues nothing
      apply_config(32'h0100_0000, 32'd0, 1'b0);
      send_frame(16'h7FFF, 16'h7FFF, 1'b0);
      send_frame(16'h8000, 16'h8000, 1'b0);
      send_frame(16'h0000, 16'hFFFF, 1'b1);

      // random phases of mostly well-formed streams
      target = tracker.inputs + RANDOM_ITEMS;
      while (tracker.inputs < target) begin
         apply_config(draw_step(), draw_total(), 1'($urandom_range(0, 1)));
         tx_busy = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(2, 4)) begin
            len    = $urandom_range(1, 8);
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++)
               send_frame(draw_sample(), draw_sample(), (i == len - 1) && !broken);
         end
      end

      settle_idle();
      $display("Run covered %0d input beats in %0d closed streams and %0d result beats",
               tracker.inputs, tracker.streams, tracker.results);
      $display("across %0d register settings, %0d mismatches",
               tracker.settings, tracker.errors);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/srs_pkg.sv
hw/rtl/srs_mul.sv
hw/rtl/srs_div.sv
hw/rtl/stereo_linear_resampler.sv
verif/testbench.sv
